// File: src/heightfield_bilinear_sampler_macros.svh
// Assertion macros shared by the height field sampler.
`ifndef HEIGHTFIELD_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHTFIELD_BILINEAR_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define HBS_CHECK(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define HBS_CHECK_NEXT(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

// File: src/hbs_pkg.sv
// Shared types, codes and helpers of the height field sampler.
package hbs_pkg;

	localparam int SPW = 31;
	localparam int ADDR_W = 5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [2:0] REG_X_ORIGIN = 3'd0;
	localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
	localparam logic [2:0] REG_X_SPACING = 3'd2;
	localparam logic [2:0] REG_Y_SPACING = 3'd3;
	localparam logic [2:0] REG_GAIN = 3'd4;
	localparam logic [2:0] REG_BIAS = 3'd5;
	localparam logic [2:0] REG_ROWS = 3'd6;
	localparam logic [2:0] REG_COLS = 3'd7;

	typedef struct packed {
		logic               op;
		logic [7:0]         row;
		logic [7:0]         col;
		logic signed [15:0] sample;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} hbs_cmd_t;

	typedef struct packed {
		logic signed [31:0] height;
		logic signed [31:0] slope_x;
		logic signed [31:0] slope_y;
	} hbs_res_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7fff_ffff) begin
			r = 32'sh7fff_ffff;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: src/hbs_fdiv.sv
// Pipelined floor divider of a signed word by a positive divisor, one bit per stage.
module hbs_fdiv import hbs_pkg::*; #(
	parameter int NW = 64
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic [SPW-1:0]       den,
	output logic signed [NW-1:0] quo,
	output logic [SPW-1:0]       rem
);
	localparam int UW = NW - 1;

	logic [UW-1:0]  nq_s [UW+1];
	logic [SPW-1:0] rm_s [UW+1];
	logic           neg_s [UW+1];

	// A negative word is divided as its complement and corrected at the end.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= num[NW-1];
			nq_s[0] <= num[NW-1] ? ~num[UW-1:0] : num[UW-1:0];
			rm_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < UW; g++) begin : g_step
		logic [SPW:0] trial;
		logic         fits;
		assign trial = {rm_s[g], nq_s[g][UW-1]};
		assign fits = trial >= {1'b0, den};
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[g+1] <= neg_s[g];
				nq_s[g+1] <= {nq_s[g][UW-2:0], fits};
				rm_s[g+1] <= fits ? SPW'(trial - {1'b0, den}) : SPW'(trial);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[UW] ? $signed(~{1'b0, nq_s[UW]}) : $signed({1'b0, nq_s[UW]});
			rem <= neg_s[UW] ? den - SPW'(1) - rm_s[UW] : rm_s[UW];
		end
	end

endmodule

// File: src/hbs_delay.sv
// Delay line that keeps side data and valid bits aligned with a divider.
module hbs_delay import hbs_pkg::*; #(
	parameter int W = 8,
	parameter int D = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] line_s [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) begin
				line_s[i] <= '0;
			end
		end else if (en) begin
			line_s[0] <= din;
			for (int i = 1; i < D; i++) begin
				line_s[i] <= line_s[i-1];
			end
		end
	end

	assign dout = line_s[D-1];

endmodule

// File: src/hbs_grid.sv
// Sample grid in four banks split by row and column parity, four corners per cycle while en is high.
module hbs_grid import hbs_pkg::*; #(
	parameter int RW = 8,
	parameter int CW = 8
) (
	input  logic               clk,
	input  logic               en,
	input  logic               we,
	input  logic [RW-1:0]      wrow,
	input  logic [CW-1:0]      wcol,
	input  logic [15:0]        wdata,
	input  logic [RW-1:0]      r0,
	input  logic [RW-1:0]      r1,
	input  logic [CW-1:0]      c0,
	input  logic [CW-1:0]      c1,
	output logic signed [15:0] corner [4]
);
	localparam int HR = (RW > 1) ? RW - 1 : 1;
	localparam int HC = (CW > 1) ? CW - 1 : 1;
	localparam int AW = HR + HC;
	localparam int BANK_DEPTH = 1 << AW;

	logic [RW-1:0] rsel [2];
	logic [CW-1:0] csel [2];
	logic [15:0]   rd_q [4];
	logic [3:0]    par_q;
	logic [1:0]    wbank;
	logic [AW-1:0] waddr;

	assign wbank = {wrow[0], wcol[0]};
	assign waddr = {HR'(wrow >> 1), HC'(wcol >> 1)};

	for (genvar p = 0; p < 2; p++) begin : g_sel
		assign rsel[p] = (r0[0] == 1'(p)) ? r0 : r1;
		assign csel[p] = (c0[0] == 1'(p)) ? c0 : c1;
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [15:0]   mem [BANK_DEPTH];
		logic [AW-1:0] raddr;
		assign raddr = {HR'(rsel[b/2] >> 1), HC'(csel[b%2] >> 1)};
		always_ff @(posedge clk) begin
			if (en) begin
				if (we && wbank == 2'(b)) begin
					mem[waddr] <= wdata;
				end
				rd_q[b] <= mem[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			par_q <= {r0[0], r1[0], c0[0], c1[0]};
		end
	end

	assign corner[0] = $signed(rd_q[{par_q[3], par_q[1]}]);
	assign corner[1] = $signed(rd_q[{par_q[3], par_q[0]}]);
	assign corner[2] = $signed(rd_q[{par_q[2], par_q[1]}]);
	assign corner[3] = $signed(rd_q[{par_q[2], par_q[0]}]);

endmodule

// File: src/heightfield_bilinear_sampler.sv
// Height field sampler top level: bilinear height and slopes from a stored sample grid.
// A query word gives a result; a write word gives none.
// One word is taken every cycle while the result side keeps up; three groups of pipelined
// dividers, the single stages s1 to s7 and the output register set the depth.
// The pipeline holds only while a stalled result has a valid word right behind it.
// Reset clears all valid bits and loads the register defaults; grid contents stay undefined.
`include "heightfield_bilinear_sampler_macros.svh"
module heightfield_bilinear_sampler import hbs_pkg::*; #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  hbs_cmd_t          cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output hbs_res_t          res
);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int RCW = ($clog2(MAX_ROWS + 1) > 9) ? $clog2(MAX_ROWS + 1) : 9;
	localparam int CCW = ($clog2(MAX_COLS + 1) > 9) ? $clog2(MAX_COLS + 1) : 9;
	localparam int LOC_NW = 33;
	localparam int LERP_NW = 64;
	localparam int LOC_LAT = LOC_NW + 1;
	localparam int LERP_LAT = LERP_NW + 1;

	typedef struct packed {
		logic               v;
		logic               op;
		logic [7:0]         row;
		logic [7:0]         col;
		logic signed [15:0] sample;
	} side_a_t;

	typedef struct packed {
		logic               v;
		logic signed [31:0] z00;
		logic signed [31:0] z01;
		logic signed [31:0] z10;
		logic [SPW-1:0]     fx;
	} side_b_t;

	typedef struct packed {
		logic               v;
		logic signed [31:0] a0;
	} side_c_t;

	logic signed [31:0] x_org_q, y_org_q, gain_q, bias_q;
	logic [SPW-1:0]     x_sp_q, y_sp_q;
	logic [8:0]         rows_q, cols_q;
	logic [SPW-1:0]     xs, ys;
	logic [RCW-1:0]     rows_eff;
	logic [CCW-1:0]     cols_eff;
	logic [RW-1:0]      last_row;
	logic [CW-1:0]      last_col;

	logic en, out_free, out_v_q;
	hbs_res_t res_q;

	logic signed [LOC_NW-1:0] dx, dy, kx, ky;
	logic [SPW-1:0]           rx, ry;
	side_a_t                  a_in, a_o;
	logic [RW-1:0]            loc_r0, loc_r1;
	logic [CW-1:0]            loc_c0, loc_c1;
	logic [SPW-1:0]           loc_fx, loc_fy;

	logic               v_s1, op_s1, wok_s1;
	logic [RW-1:0]      r0_s1, r1_s1, wrow_s1;
	logic [CW-1:0]      c0_s1, c1_s1, wcol_s1;
	logic [SPW-1:0]     fx_s1, fy_s1;
	logic [15:0]        wdata_s1;
	logic signed [15:0] corner [4];

	logic               v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [SPW-1:0]     fx_s2, fy_s2, fx_s3, fy_s3, fx_s4, fy_s4, fx_s5, fx_s6;
	logic signed [47:0] p_s3 [4];
	logic signed [31:0] z_s4 [4];
	logic signed [31:0] z00_s5, z01_s5, z10_s5;
	logic signed [LERP_NW-1:0] e_s5 [4];
	logic signed [LERP_NW-1:0] q1 [4];
	side_b_t            b_in, b_o;
	logic signed [33:0] a0w, a1w, k0w, k1w;
	logic signed [31:0] a0_s6, a0_s7;
	logic signed [32:0] dh_s6, ds_s6;
	logic signed [LERP_NW-1:0] nh_s7, nx_s7, ny_s7, qh, qx, qy;
	side_c_t            c_in, c_o;
	logic signed [33:0] hw;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_org_q <= '0;
			y_org_q <= '0;
			x_sp_q <= SPW'(65536);
			y_sp_q <= SPW'(65536);
			gain_q <= 32'sd65536;
			bias_q <= '0;
			rows_q <= 9'd256;
			cols_q <= 9'd256;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
				REG_X_ORIGIN: x_org_q <= pwdata;
				REG_Y_ORIGIN: y_org_q <= pwdata;
				REG_X_SPACING: x_sp_q <= pwdata[SPW-1:0];
				REG_Y_SPACING: y_sp_q <= pwdata[SPW-1:0];
				REG_GAIN: gain_q <= pwdata;
				REG_BIAS: bias_q <= pwdata;
				REG_ROWS: rows_q <= pwdata[8:0];
				REG_COLS: cols_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_X_ORIGIN: prdata = x_org_q;
			REG_Y_ORIGIN: prdata = y_org_q;
			REG_X_SPACING: prdata = 32'(x_sp_q);
			REG_Y_SPACING: prdata = 32'(y_sp_q);
			REG_GAIN: prdata = gain_q;
			REG_BIAS: prdata = bias_q;
			REG_ROWS: prdata = 32'(rows_q);
			REG_COLS: prdata = 32'(cols_q);
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	assign xs = (x_sp_q == '0) ? SPW'(1) : x_sp_q;
	assign ys = (y_sp_q == '0) ? SPW'(1) : y_sp_q;
	assign rows_eff = (rows_q == '0) ? RCW'(1) :
		(RCW'(rows_q) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_q);
	assign cols_eff = (cols_q == '0) ? CCW'(1) :
		(CCW'(cols_q) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cols_q);
	assign last_row = RW'(rows_eff - RCW'(1));
	assign last_col = CW'(cols_eff - CCW'(1));

	// The pipeline moves unless a stalled result meets a word behind it.
	assign out_free = !out_v_q || !res_stall;
	assign en = out_free || !c_o.v;
	assign cmd_stall = !en;

	// Cell search: floor division of the offset by the spacing on both axes.
	assign dx = LOC_NW'(cmd.pos_x) - LOC_NW'(x_org_q);
	assign dy = LOC_NW'(cmd.pos_y) - LOC_NW'(y_org_q);
	assign a_in = '{v: cmd_valid, op: cmd.op, row: cmd.row, col: cmd.col,
		sample: cmd.sample};

	hbs_fdiv #(.NW(LOC_NW)) u_div_kx (.clk, .en, .num(dx), .den(xs), .quo(kx), .rem(rx));
	hbs_fdiv #(.NW(LOC_NW)) u_div_ky (.clk, .en, .num(dy), .den(ys), .quo(ky), .rem(ry));
	hbs_delay #(.W($bits(side_a_t)), .D(LOC_LAT)) u_dly_a (
		.clk, .arst_n, .en, .din(a_in), .dout(a_o)
	);

	always_comb begin
		loc_r0 = '0;
		loc_r1 = '0;
		loc_fx = '0;
		if (kx < 0) begin
			loc_r0 = '0;
		end else if (kx >= $signed(LOC_NW'(last_row))) begin
			loc_r0 = last_row;
			loc_r1 = last_row;
		end else begin
			loc_r0 = RW'(kx);
			loc_r1 = RW'(kx) + RW'(1);
			loc_fx = rx;
		end
	end

	always_comb begin
		loc_c0 = '0;
		loc_c1 = '0;
		loc_fy = '0;
		if (ky < 0) begin
			loc_c0 = '0;
		end else if (ky >= $signed(LOC_NW'(last_col))) begin
			loc_c0 = last_col;
			loc_c1 = last_col;
		end else begin
			loc_c0 = CW'(ky);
			loc_c1 = CW'(ky) + CW'(1);
			loc_fy = ry;
		end
	end

	hbs_grid #(.RW(RW), .CW(CW)) u_grid (
		.clk,
		.en,
		.we(en && v_s1 && op_s1 == OP_WRITE && wok_s1),
		.wrow(wrow_s1),
		.wcol(wcol_s1),
		.wdata(wdata_s1),
		.r0(r0_s1),
		.r1(r1_s1),
		.c0(c0_s1),
		.c1(c1_s1),
		.corner
	);

	// Bilinear blends per row and per column.
	assign b_in = '{v: v_s5, z00: z00_s5, z01: z01_s5, z10: z10_s5, fx: fx_s5};

	hbs_fdiv #(.NW(LERP_NW)) u_div_a0 (.clk, .en, .num(e_s5[0]), .den(ys), .quo(q1[0]), .rem());
	hbs_fdiv #(.NW(LERP_NW)) u_div_a1 (.clk, .en, .num(e_s5[1]), .den(ys), .quo(q1[1]), .rem());
	hbs_fdiv #(.NW(LERP_NW)) u_div_k0 (.clk, .en, .num(e_s5[2]), .den(xs), .quo(q1[2]), .rem());
	hbs_fdiv #(.NW(LERP_NW)) u_div_k1 (.clk, .en, .num(e_s5[3]), .den(xs), .quo(q1[3]), .rem());
	hbs_delay #(.W($bits(side_b_t)), .D(LERP_LAT)) u_dly_b (
		.clk, .arst_n, .en, .din(b_in), .dout(b_o)
	);

	assign a0w = 34'(b_o.z00) + 34'(q1[0]);
	assign a1w = 34'(b_o.z10) + 34'(q1[1]);
	assign k0w = 34'(b_o.z00) + 34'(q1[2]);
	assign k1w = 34'(b_o.z01) + 34'(q1[3]);

	// Final blend along x and the two slopes.
	assign c_in = '{v: v_s7, a0: a0_s7};

	hbs_fdiv #(.NW(LERP_NW)) u_div_h (.clk, .en, .num(nh_s7), .den(xs), .quo(qh), .rem());
	hbs_fdiv #(.NW(LERP_NW)) u_div_sx (.clk, .en, .num(nx_s7), .den(xs), .quo(qx), .rem());
	hbs_fdiv #(.NW(LERP_NW)) u_div_sy (.clk, .en, .num(ny_s7), .den(ys), .quo(qy), .rem());
	hbs_delay #(.W($bits(side_c_t)), .D(LERP_LAT)) u_dly_c (
		.clk, .arst_n, .en, .din(c_in), .dout(c_o)
	);

	assign hw = 34'(c_o.a0) + 34'(qh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= a_o.v;
				v_s2 <= v_s1 && op_s1 == OP_QUERY;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= b_o.v;
				v_s7 <= v_s6;
			end
			if (out_free) begin
				out_v_q <= c_o.v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= a_o.op;
			wok_s1 <= (32'(a_o.row) < MAX_ROWS) && (32'(a_o.col) < MAX_COLS);
			wrow_s1 <= RW'(a_o.row);
			wcol_s1 <= CW'(a_o.col);
			wdata_s1 <= a_o.sample;
			r0_s1 <= loc_r0;
			r1_s1 <= loc_r1;
			c0_s1 <= loc_c0;
			c1_s1 <= loc_c1;
			fx_s1 <= loc_fx;
			fy_s1 <= loc_fy;

			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;

			for (int i = 0; i < 4; i++) begin
				p_s3[i] <= 48'(corner[i]) * 48'(gain_q);
				z_s4[i] <= sat32(64'(p_s3[i]) + 64'(bias_q));
			end
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;

			e_s5[0] <= LERP_NW'(33'(z_s4[1]) - 33'(z_s4[0])) *
				LERP_NW'($signed({1'b0, fy_s4}));
			e_s5[1] <= LERP_NW'(33'(z_s4[3]) - 33'(z_s4[2])) *
				LERP_NW'($signed({1'b0, fy_s4}));
			e_s5[2] <= LERP_NW'(33'(z_s4[2]) - 33'(z_s4[0])) *
				LERP_NW'($signed({1'b0, fx_s4}));
			e_s5[3] <= LERP_NW'(33'(z_s4[3]) - 33'(z_s4[1])) *
				LERP_NW'($signed({1'b0, fx_s4}));
			z00_s5 <= z_s4[0];
			z01_s5 <= z_s4[1];
			z10_s5 <= z_s4[2];
			fx_s5 <= fx_s4;

			a0_s6 <= a0w[31:0];
			dh_s6 <= 33'(a1w) - 33'(a0w);
			ds_s6 <= 33'(k1w) - 33'(k0w);
			fx_s6 <= b_o.fx;

			a0_s7 <= a0_s6;
			nh_s7 <= LERP_NW'(dh_s6) * LERP_NW'($signed({1'b0, fx_s6}));
			nx_s7 <= LERP_NW'(dh_s6) <<< 16;
			ny_s7 <= LERP_NW'(ds_s6) <<< 16;
		end
		if (out_free) begin
			res_q.height <= hw[31:0];
			res_q.slope_x <= sat32(qx);
			res_q.slope_y <= sat32(qy);
		end
	end

	assign res_valid = out_v_q;
	assign res = res_q;

	`HBS_CHECK(a_cell_pair, v_s1, (r1_s1 == r0_s1) || (r1_s1 == r0_s1 + RW'(1)), "row pair is not adjacent")
	`HBS_CHECK(a_edge_flat, v_s1 && (r0_s1 == r1_s1), fx_s1 == '0, "clamped row with nonzero fraction")
	`HBS_CHECK(a_hold_in, out_v_q && res_stall && c_o.v, cmd_stall, "word taken while pipeline is full")
	`HBS_CHECK_NEXT(a_hold_pipe, out_v_q && res_stall && c_o.v, $stable(v_s1) && $stable(v_s6), "pipeline moved while held")

endmodule
